// ----- design/trlc_pkg.sv -----
// Shared types, constants and letter arithmetic of the three-rotor letter cipher.
package trlc_pkg;

  localparam int Letters     = 26;
  localparam int LetterWidth = 5;
  localparam int Rotors      = 3;
  localparam int Stages      = 6;
  localparam int QueueDepth  = 2;
  localparam int CfgIdxWidth = 2;

  localparam logic [LetterWidth-1:0] LastLetter = LetterWidth'(Letters - 1);

  localparam logic       ReqLoad    = 1'b0;
  localparam logic       ReqEncrypt = 1'b1;

  localparam logic [1:0] SelSlow   = 2'd0;
  localparam logic [1:0] SelMiddle = 2'd1;
  localparam logic [1:0] SelFast   = 2'd2;
  localparam logic [1:0] SelNone   = 2'd3;

  localparam logic [CfgIdxWidth-1:0] RegFastNotch   = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] RegMiddleNotch = CfgIdxWidth'(1);

  localparam int ReflectStage = 2;

  localparam logic [1:0] StageRotor [Stages] = '{
    SelFast, SelMiddle, SelSlow, SelSlow, SelMiddle, SelFast
  };
  localparam logic StageInverse [Stages] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

  localparam logic [LetterWidth-1:0] Reflector [Letters] = '{
    5'd24, 5'd17, 5'd20, 5'd7,  5'd16, 5'd18, 5'd11, 5'd3,  5'd15,
    5'd23, 5'd13, 5'd6,  5'd14, 5'd10, 5'd12, 5'd8,  5'd4,  5'd1,
    5'd5,  5'd25, 5'd2,  5'd22, 5'd21, 5'd9,  5'd0,  5'd19
  };

  typedef logic [LetterWidth-1:0] letter_t;

  typedef struct packed {
    letter_t fast;
    letter_t middle;
    letter_t slow;
  } pos_t;

  typedef struct packed {
    letter_t fast_notch;
    letter_t middle_notch;
  } cfg_t;

  typedef struct packed {
    logic       is_enc;
    logic [1:0] sel;
    letter_t    widx;
    letter_t    wlet;
    letter_t    letter;
    pos_t       pos;
  } entry_t;

  function automatic letter_t add_mod(letter_t a, letter_t b);
    logic [LetterWidth:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LetterWidth+1)'(Letters)) begin
      s = s - (LetterWidth+1)'(Letters);
    end
    return s[LetterWidth-1:0];
  endfunction

  function automatic letter_t sub_mod(letter_t w, letter_t p);
    logic [LetterWidth:0] s;
    if (w >= p) begin
      s = {1'b0, w} - {1'b0, p};
    end else begin
      s = {1'b0, w} + (LetterWidth+1)'(Letters) - {1'b0, p};
    end
    return s[LetterWidth-1:0];
  endfunction

  function automatic letter_t reduce(letter_t x);
    letter_t r;
    r = x;
    if (x >= LetterWidth'(Letters)) begin
      r = x - LetterWidth'(Letters);
    end
    return r;
  endfunction

  function automatic letter_t advance(letter_t p);
    letter_t r;
    r = p + LetterWidth'(1);
    if (p == LastLetter) begin
      r = '0;
    end
    return r;
  endfunction

  function automatic letter_t pos_of(pos_t p, logic [1:0] sel);
    letter_t r;
    case (sel)
      SelSlow:   r = p.slow;
      SelMiddle: r = p.middle;
      SelFast:   r = p.fast;
      default:   r = p.fast;
    endcase
    return r;
  endfunction

endpackage

// ----- design/trlc_front.sv -----
// Front end: request intake, rotor stepping and load filtering.
module trlc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  req_type_i,
  input  logic [1:0]            rotor_select_i,
  input  trlc_pkg::letter_t     wiring_index_i,
  input  trlc_pkg::letter_t     wiring_letter_i,
  input  trlc_pkg::letter_t     plain_letter_i,
  input  trlc_pkg::cfg_t        cfg_i,
  output logic                  push_o,
  output trlc_pkg::entry_t      entry_o,
  output trlc_pkg::pos_t        pos_o
);

  trlc_pkg::pos_t pos_q, pos_d;
  logic           load_ok;

  always_comb begin
    pos_d = pos_q;
    if (accept_i && req_type_i == trlc_pkg::ReqEncrypt) begin
      pos_d.fast = trlc_pkg::advance(pos_q.fast);
      if (pos_d.fast == cfg_i.fast_notch) begin
        pos_d.middle = trlc_pkg::advance(pos_q.middle);
        if (pos_d.middle == cfg_i.middle_notch) begin
          pos_d.slow = trlc_pkg::advance(pos_q.slow);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // drop loads with a bad rotor, contact or letter
  assign load_ok = (rotor_select_i != trlc_pkg::SelNone)
                && (wiring_index_i < trlc_pkg::LetterWidth'(trlc_pkg::Letters))
                && (wiring_letter_i < trlc_pkg::LetterWidth'(trlc_pkg::Letters));

  assign push_o = accept_i && (req_type_i == trlc_pkg::ReqEncrypt || load_ok);

  always_comb begin
    entry_o.is_enc = req_type_i;
    entry_o.sel    = rotor_select_i;
    entry_o.widx   = wiring_index_i;
    entry_o.wlet   = wiring_letter_i;
    entry_o.letter = trlc_pkg::reduce(plain_letter_i);
    entry_o.pos    = pos_d;
  end

  assign pos_o = pos_q;

endmodule

// ----- design/trlc_queue.sv -----
// Short request queue between the front end and the substitution pipeline.
module trlc_queue #(
  parameter int Depth = trlc_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  trlc_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output trlc_pkg::entry_t  head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  trlc_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = p + PtrW'(1);
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end
    return r;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- design/trlc_back.sv -----
// Back end: six-stage rotor and reflector pipeline holding the wiring tables.
module trlc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  trlc_pkg::entry_t  entry_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output trlc_pkg::entry_t  out_entry_o
);

  localparam int S = trlc_pkg::Stages;

  trlc_pkg::letter_t fwd_q [trlc_pkg::Rotors][trlc_pkg::Letters];
  trlc_pkg::letter_t inv_q [trlc_pkg::Rotors][trlc_pkg::Letters];

  trlc_pkg::entry_t  st_q  [S];
  logic [S-1:0]      st_v_q;
  trlc_pkg::entry_t  in_e  [S];
  logic [S-1:0]      in_v;
  trlc_pkg::entry_t  nxt   [S];
  logic              adv;

  assign out_valid_o = st_v_q[S-1] && st_q[S-1].is_enc;
  assign adv         = !(out_valid_o && out_stall_i);
  assign advance_o   = adv;
  assign out_entry_o = st_q[S-1];

  always_comb begin
    in_e[0] = entry_i;
    in_v[0] = valid_i;
    for (int k = 1; k < S; k++) begin
      in_e[k] = st_q[k-1];
      in_v[k] = st_v_q[k-1];
    end
  end

  always_comb begin
    trlc_pkg::letter_t p;
    trlc_pkg::letter_t c;
    trlc_pkg::letter_t w;
    trlc_pkg::letter_t x;
    for (int k = 0; k < S; k++) begin
      p = trlc_pkg::pos_of(in_e[k].pos, trlc_pkg::StageRotor[k]);
      c = trlc_pkg::add_mod(in_e[k].letter, p);
      if (trlc_pkg::StageInverse[k]) begin
        w = inv_q[trlc_pkg::StageRotor[k]][c];
      end else begin
        w = fwd_q[trlc_pkg::StageRotor[k]][c];
      end
      x = trlc_pkg::sub_mod(w, p);
      if (k == trlc_pkg::ReflectStage) begin
        x = trlc_pkg::Reflector[x];
      end
      nxt[k]        = in_e[k];
      nxt[k].letter = x;
    end
  end

  // write each table as the load passes the stage that reads it
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < S; k++) begin
      if (adv && in_v[k] && !in_e[k].is_enc
          && in_e[k].sel == trlc_pkg::StageRotor[k]) begin
        if (trlc_pkg::StageInverse[k]) begin
          inv_q[trlc_pkg::StageRotor[k]][in_e[k].wlet] <= in_e[k].widx;
        end else begin
          fwd_q[trlc_pkg::StageRotor[k]][in_e[k].widx] <= in_e[k].wlet;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < S; k++) begin
        st_q[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= '0;
    end else if (adv) begin
      st_v_q <= in_v;
    end
  end

endmodule

// ----- design/three_rotor_letter_cipher_unit.sv -----
// Top level of the three-rotor letter cipher with reflector B.
//
// Requests enter on the in_ channel (valid/stall); a request is taken at a
// clock edge with in_valid_i high and in_stall_o low. A load request writes
// one forward wiring entry of one rotor and the matching inverse entry and
// gives no result. An encrypt request steps the rotors and gives one result
// on the out_ channel: the cipher letter and the three positions after
// stepping. Loads with a bad rotor, contact or letter are dropped.
// One request per cycle is sustained while no result is stalled, set by
// the six-stage lookup pipeline behind a two-entry queue. The user writes
// notches on the cfg_ port only while idle; the block does not enforce it.
// Reset zeroes the positions and notches and empties queue and pipeline;
// wiring tables hold no value until loaded. While out_stall_i holds a
// result, the pipeline freezes, the queue fills, and then in_stall_o rises.
module three_rotor_letter_cipher_unit #(
  parameter int QueueDepth = trlc_pkg::QueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [1:0]                          rotor_select_i,
  input  logic [trlc_pkg::LetterWidth-1:0]    wiring_index_i,
  input  logic [trlc_pkg::LetterWidth-1:0]    wiring_letter_i,
  input  logic [trlc_pkg::LetterWidth-1:0]    plain_letter_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [trlc_pkg::LetterWidth-1:0]    cipher_letter_o,
  output logic [trlc_pkg::LetterWidth-1:0]    fast_position_o,
  output logic [trlc_pkg::LetterWidth-1:0]    middle_position_o,
  output logic [trlc_pkg::LetterWidth-1:0]    slow_position_o,
  input  logic                                cfg_we_i,
  input  logic [trlc_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [trlc_pkg::LetterWidth-1:0]    cfg_wdata_i
);

  trlc_pkg::cfg_t   cfg_q;
  logic             accept;
  logic             push;
  trlc_pkg::entry_t push_entry;
  trlc_pkg::pos_t   front_pos;
  logic             q_full;
  logic             q_valid;
  trlc_pkg::entry_t q_head;
  logic             adv;
  trlc_pkg::entry_t out_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        trlc_pkg::RegFastNotch:   cfg_q.fast_notch   <= cfg_wdata_i;
        trlc_pkg::RegMiddleNotch: cfg_q.middle_notch <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  trlc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .req_type_i      (req_type_i),
    .rotor_select_i  (rotor_select_i),
    .wiring_index_i  (wiring_index_i),
    .wiring_letter_i (wiring_letter_i),
    .plain_letter_i  (plain_letter_i),
    .cfg_i           (cfg_q),
    .push_o          (push),
    .entry_o         (push_entry),
    .pos_o           (front_pos)
  );

  trlc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (adv),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  trlc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (q_head),
    .advance_o   (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_entry_o (out_entry)
  );

  assign cipher_letter_o   = out_entry.letter;
  assign fast_position_o   = out_entry.pos.fast;
  assign middle_position_o = out_entry.pos.middle;
  assign slow_position_o   = out_entry.pos.slow;

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && req_type_i == trlc_pkg::ReqEncrypt) |=> $stable(front_pos))
    else $error("rotor positions moved without an encrypt request");

  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !adv |=> q_valid && $stable(q_head))
    else $error("queue head changed while the pipeline was frozen");

  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !push_entry.is_enc |->
      push_entry.sel != trlc_pkg::SelNone
      && push_entry.widx < trlc_pkg::LetterWidth'(trlc_pkg::Letters)
      && push_entry.wlet < trlc_pkg::LetterWidth'(trlc_pkg::Letters))
    else $error("out of range load request queued");

endmodule
